// File: sv/kaa_pkg.sv
// Package for the k-means assign/accumulate block: types, codes and constants.
package kaa_pkg;

   localparam int DEF_MAX_CLUSTERS = 16;
   localparam int DEF_MAX_DIMS     = 64;
   localparam int DEF_MAX_ROWS     = 4096;
   localparam int DEF_COORD_WIDTH  = 16;

   localparam int DIST_WIDTH  = 40;
   localparam int SUM_WIDTH   = 32;
   localparam int COUNT_WIDTH = 13;
   localparam int SQ_LIMIT_BITS = 20;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 7;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_CLUSTERS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_DIMS     = 2'd1;

   localparam logic KIND_ASSIGN  = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_POINT = 2'd1,
      ACT_START = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIST_RD,
      ST_DIST_SQ,
      ST_DIST_ACC,
      ST_MIN,
      ST_PRIOR_RD,
      ST_PRIOR_UPD,
      ST_SUM_RD,
      ST_SUM_WR,
      ST_READ_RD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic c_clr;
      logic c_inc;
      logic dist_rd;
      logic dist_sq;
      logic dist_acc;
      logic min_step;
      logic prior_rd;
      logic prior_upd;
      logic d_clr;
      logic d_inc;
      logic sum_rd;
      logic sum_wr;
      logic rd_issue;
      logic out_load;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      action_type req_action;
      logic       req_last;
      logic       req_dim_ok;
      logic       item_last;
      logic       c_last;
      logic       d_last;
      logic       clear_done;
      logic       out_busy;
   } status_type;

endpackage

// File: sv/kaa_if.sv
// Channel interfaces: request, response and register write.
interface kaa_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [3:0]                    cluster_index;
   logic [5:0]                    dim_index;
   logic [11:0]                   row_index;
   logic signed [COORD_WIDTH-1:0] coord_value;
   logic                          last_coord;
   modport source (output valid, action, cluster_index, dim_index, row_index, coord_value,
                   last_coord, input ready);
   modport sink (input valid, action, cluster_index, dim_index, row_index, coord_value,
                 last_coord, output ready);
endinterface

interface kaa_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [3:0]         chosen_cluster;
   logic               assignment_changed;
   logic [39:0]        nearest_distance;
   logic signed [31:0] member_sum;
   logic [12:0]        member_count;
   logic [12:0]        changed_total;
   modport source (output valid, result_kind, chosen_cluster, assignment_changed,
                   nearest_distance, member_sum, member_count, changed_total, input ready);
   modport sink (input valid, result_kind, chosen_cluster, assignment_changed,
                 nearest_distance, member_sum, member_count, changed_total, output ready);
endinterface

interface kaa_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] reg_index;
   logic [6:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: sv/kaa_ctrl.sv
// Controller state machine for the k-means assign/accumulate block.
module kaa_ctrl
   import kaa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (status.req_action)
                  ACT_POINT: begin
                     if (status.req_dim_ok) state_in = ST_DIST_RD;
                     else if (status.req_last) state_in = ST_MIN;
                  end
                  ACT_READ: state_in = ST_READ_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIST_RD:  state_in = ST_DIST_SQ;
         ST_DIST_SQ:  state_in = ST_DIST_ACC;
         ST_DIST_ACC: begin
            if (!status.c_last) state_in = ST_DIST_RD;
            else if (status.item_last) state_in = ST_MIN;
            else state_in = ST_IDLE;
         end
         ST_MIN: begin
            if (status.c_last) state_in = ST_PRIOR_RD;
         end
         ST_PRIOR_RD:  state_in = ST_PRIOR_UPD;
         ST_PRIOR_UPD: state_in = ST_SUM_RD;
         ST_SUM_RD:    state_in = ST_SUM_WR;
         ST_SUM_WR:    state_in = status.d_last ? ST_OUT : ST_SUM_RD;
         ST_READ_RD:   state_in = ST_OUT;
         ST_OUT: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.c_clr     = 1'b1;
         end
         ST_DIST_RD: cmd.dist_rd = 1'b1;
         ST_DIST_SQ: cmd.dist_sq = 1'b1;
         ST_DIST_ACC: begin
            cmd.dist_acc = 1'b1;
            if (status.c_last) cmd.c_clr = 1'b1;
            else cmd.c_inc = 1'b1;
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            cmd.c_inc    = !status.c_last;
         end
         ST_PRIOR_RD: cmd.prior_rd = 1'b1;
         ST_PRIOR_UPD: begin
            cmd.prior_upd = 1'b1;
            cmd.d_clr     = 1'b1;
         end
         ST_SUM_RD: cmd.sum_rd = 1'b1;
         ST_SUM_WR: begin
            cmd.sum_wr = 1'b1;
            cmd.d_inc  = !status.d_last;
         end
         ST_READ_RD: cmd.rd_issue = 1'b1;
         ST_OUT: cmd.out_load = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

// File: sv/kaa_datapath.sv
// Datapath: stores, distance unit, argmin, sum update and output register.
module kaa_datapath
   import kaa_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
   input  logic       clock,
   input  logic       reset,
   kaa_req_if.sink    req,
   kaa_rsp_if.source  rsp,
   kaa_csr_if.sink    csr,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int CIW = $clog2(MAX_CLUSTERS);
   localparam int CCW = $clog2(MAX_CLUSTERS + 1);
   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DCW = $clog2(MAX_DIMS + 1);
   localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AW  = (MAX_CLUSTERS * MAX_DIMS > 1) ? $clog2(MAX_CLUSTERS * MAX_DIMS) : 1;

   // register file
   logic [4:0] active_clusters_ff;
   logic [6:0] active_dims_ff;
   logic [CCW-1:0] nc;
   logic [DCW-1:0] nd;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_clusters_ff <= 5'd16;
         active_dims_ff     <= 7'd64;
      end else if (csr.valid) begin
         if (csr.reg_index == CSR_ACTIVE_CLUSTERS) active_clusters_ff <= csr.wdata[4:0];
         if (csr.reg_index == CSR_ACTIVE_DIMS) active_dims_ff <= csr.wdata;
      end
   end

   always_comb begin
      if (active_clusters_ff == 5'd0) nc = CCW'(1);
      else if (int'(active_clusters_ff) > MAX_CLUSTERS) nc = CCW'(MAX_CLUSTERS);
      else nc = CCW'(active_clusters_ff);
      if (active_dims_ff == 7'd0) nd = DCW'(1);
      else if (int'(active_dims_ff) > MAX_DIMS) nd = DCW'(MAX_DIMS);
      else nd = DCW'(active_dims_ff);
   end

   // item register
   logic take;
   action_type req_act;
   logic req_dim_ok;
   logic [3:0] cl_ff;
   logic [5:0] dim_ff;
   logic [RIW-1:0] row_ff;
   logic signed [COORD_WIDTH-1:0] coord_ff;
   logic last_ff;
   action_type act_ff;

   assign req.ready  = cmd.req_ready;
   assign take       = req.valid && cmd.req_ready;
   assign req_act    = action_type'(req.action);
   assign req_dim_ok = int'(req.dim_index) < int'(nd);

   always_ff @(posedge clock) begin
      if (take) begin
         cl_ff    <= req.cluster_index;
         dim_ff   <= req.dim_index;
         row_ff   <= RIW'(int'(req.row_index) % MAX_ROWS);
         coord_ff <= req.coord_value;
         last_ff  <= req.last_coord;
         act_ff   <= req_act;
      end
   end

   logic start_pass, point_done;
   assign start_pass = take && (req_act == ACT_START);
   assign point_done = cmd.out_load && (act_ff == ACT_POINT);

   // counters
   logic [CIW-1:0] c_ff;
   logic [DIW-1:0] d_ff;
   logic [RIW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (cmd.c_clr) c_ff <= '0;
      else if (cmd.c_inc) c_ff <= c_ff + 1'b1;
      if (cmd.d_clr) d_ff <= '0;
      else if (cmd.d_inc) d_ff <= d_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // centroid store
   logic signed [COORD_WIDTH-1:0] cen_mem [MAX_CLUSTERS*MAX_DIMS];
   logic signed [COORD_WIDTH-1:0] cen_rd_ff;
   logic load_ok;
   logic [AW-1:0] load_addr, dist_addr;

   assign load_ok   = (int'(req.cluster_index) < MAX_CLUSTERS) && (int'(req.dim_index) < MAX_DIMS);
   assign load_addr = AW'(int'(req.cluster_index) * MAX_DIMS + int'(req.dim_index));
   assign dist_addr = AW'(int'(c_ff) * MAX_DIMS + int'(dim_ff));

   always_ff @(posedge clock) begin
      if (take && req_act == ACT_LOAD && load_ok) cen_mem[load_addr] <= req.coord_value;
      if (cmd.dist_rd) cen_rd_ff <= cen_mem[dist_addr];
   end

   // point buffer with per-entry valid bits
   logic signed [COORD_WIDTH-1:0] pbuf_mem [MAX_DIMS];
   logic [MAX_DIMS-1:0] pbuf_vld_ff;
   logic signed [COORD_WIDTH-1:0] pbuf_rd_ff;
   logic pbuf_use_ff;
   logic pt_write;

   assign pt_write = take && req_act == ACT_POINT && req_dim_ok;

   always_ff @(posedge clock) begin
      if (pt_write) pbuf_mem[DIW'(req.dim_index)] <= req.coord_value;
      if (cmd.sum_rd) pbuf_rd_ff <= pbuf_mem[d_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || start_pass || point_done) begin
         pbuf_vld_ff <= '0;
      end else if (pt_write) begin
         pbuf_vld_ff[DIW'(req.dim_index)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_rd) pbuf_use_ff <= pbuf_vld_ff[d_ff] && (int'(d_ff) < int'(nd));
   end

   // distance unit: centroid read, squaring and accumulate for each cluster
   logic signed [COORD_WIDTH:0] diff;
   logic [32:0] mag;
   logic [DIST_WIDTH-1:0] sq_ff;
   logic [DIST_WIDTH-1:0] acc_ff [MAX_CLUSTERS];
   logic [DIST_WIDTH:0] acc_sum;

   assign diff = (COORD_WIDTH+1)'(coord_ff) - (COORD_WIDTH+1)'(cen_rd_ff);
   assign mag  = diff[COORD_WIDTH] ? 33'(-diff) : 33'(diff);
   assign acc_sum = {1'b0, acc_ff[c_ff]} + {1'b0, sq_ff};

   always_ff @(posedge clock) begin
      if (cmd.dist_sq) begin
         if (|mag[32:SQ_LIMIT_BITS]) sq_ff <= '1;
         else sq_ff <= DIST_WIDTH'(mag[SQ_LIMIT_BITS-1:0] * mag[SQ_LIMIT_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start_pass || point_done) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) acc_ff[i] <= '0;
      end else if (cmd.dist_acc) begin
         acc_ff[c_ff] <= acc_sum[DIST_WIDTH] ? '1 : acc_sum[DIST_WIDTH-1:0];
      end
   end

   // argmin walk, lower index wins ties
   logic [CIW-1:0] best_ff;
   logic [DIST_WIDTH-1:0] best_dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.min_step && (c_ff == '0 || acc_ff[c_ff] < best_dist_ff)) begin
         best_ff      <= c_ff;
         best_dist_ff <= acc_ff[c_ff];
      end
   end

   // prior assignment store, swept to the invalid marker after reset
   logic [CIW:0] prior_mem [MAX_ROWS];
   logic [CIW:0] prior_rd_ff;
   logic changed_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) prior_mem[clr_ff] <= (CIW+1)'(MAX_CLUSTERS);
      else if (cmd.prior_upd) prior_mem[row_ff] <= {1'b0, best_ff};
      if (cmd.prior_rd) prior_rd_ff <= prior_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.prior_upd) changed_ff <= prior_rd_ff != {1'b0, best_ff};
   end

   // counts, change counter and row-valid bits for the sum store
   logic [COUNT_WIDTH-1:0] count_ff [MAX_CLUSTERS];
   logic [COUNT_WIDTH-1:0] change_ff;
   logic [MAX_CLUSTERS-1:0] row_vld_ff;
   logic new_change;

   assign new_change = prior_rd_ff != {1'b0, best_ff};

   always_ff @(posedge clock) begin
      if (reset || start_pass) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) count_ff[i] <= '0;
         change_ff <= '0;
      end else if (cmd.prior_upd) begin
         if (count_ff[best_ff] != COUNT_MAX) count_ff[best_ff] <= count_ff[best_ff] + 1'b1;
         if (new_change && change_ff != COUNT_MAX) change_ff <= change_ff + 1'b1;
      end
   end

   // sum store walk
   logic signed [SUM_WIDTH-1:0] sum_mem [MAX_CLUSTERS*MAX_DIMS];
   logic signed [SUM_WIDTH-1:0] sum_rd_ff;
   logic [AW-1:0] sum_addr, walk_addr, rd_addr;
   logic signed [SUM_WIDTH:0] sum_new;
   logic signed [SUM_WIDTH-1:0] sum_sat, sum_old;
   int d_lim;

   assign walk_addr = AW'(int'(best_ff) * MAX_DIMS + int'(d_ff));
   assign rd_addr   = AW'(int'(cl_ff) * MAX_DIMS + int'(dim_ff));
   assign sum_addr  = cmd.rd_issue ? rd_addr : walk_addr;
   assign sum_old   = row_vld_ff[best_ff] ? sum_rd_ff : '0;
   assign sum_new   = (SUM_WIDTH+1)'(sum_old)
                    + (pbuf_use_ff ? (SUM_WIDTH+1)'(pbuf_rd_ff) : '0);
   assign d_lim     = row_vld_ff[best_ff] ? int'(nd) : MAX_DIMS;

   always_comb begin
      if (sum_new[SUM_WIDTH] != sum_new[SUM_WIDTH-1])
         sum_sat = sum_new[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      else
         sum_sat = sum_new[SUM_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_wr) sum_mem[walk_addr] <= sum_sat;
      if (cmd.sum_rd || cmd.rd_issue) sum_rd_ff <= sum_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || start_pass) row_vld_ff <= '0;
      else if (cmd.sum_wr && status.d_last) row_vld_ff[best_ff] <= 1'b1;
   end

   // response register
   logic rsp_valid_ff;
   logic rd_cl_ok, rd_sum_ok;
   logic [CIW-1:0] rd_cl;

   assign rd_cl     = CIW'(cl_ff);
   assign rd_cl_ok  = int'(cl_ff) < MAX_CLUSTERS;
   assign rd_sum_ok = rd_cl_ok && (int'(dim_ff) < MAX_DIMS) && row_vld_ff[rd_cl];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp.changed_total <= change_ff;
         if (act_ff == ACT_POINT) begin
            rsp.result_kind        <= KIND_ASSIGN;
            rsp.chosen_cluster     <= 4'(best_ff);
            rsp.assignment_changed <= changed_ff;
            rsp.nearest_distance   <= best_dist_ff;
            rsp.member_sum         <= '0;
            rsp.member_count       <= count_ff[best_ff];
         end else begin
            rsp.result_kind        <= KIND_READOUT;
            rsp.chosen_cluster     <= cl_ff;
            rsp.assignment_changed <= 1'b0;
            rsp.nearest_distance   <= '0;
            rsp.member_sum         <= rd_sum_ok ? sum_rd_ff : '0;
            rsp.member_count       <= rd_cl_ok ? count_ff[rd_cl] : '0;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // status
   assign status.req_action = req_act;
   assign status.req_last   = req.last_coord;
   assign status.req_dim_ok = req_dim_ok;
   assign status.item_last  = last_ff;
   assign status.c_last     = int'(c_ff) == int'(nc) - 1;
   assign status.d_last     = int'(d_ff) == d_lim - 1;
   assign status.clear_done = int'(clr_ff) == MAX_ROWS - 1;
   assign status.out_busy   = rsp_valid_ff && !rsp.ready;

endmodule

// File: sv/kmeans_assign_accumulate.sv
// Top level of the k-means assignment and accumulation block.
// Usage: load centroid coordinates (load transactions), issue a start transaction to
// open a pass, then stream each point one coordinate per transaction with last_coord
// on its final coordinate. A point end returns one assignment response; a readout
// transaction returns one cluster's member sum at one dimension with its count.
// Load and start transactions return nothing.
// Channels: req_bus (sink), rsp_bus (source), csr_bus (register writes, always ready;
// write only while the block is idle).
// Sequencing: one transaction in flight. A load or start is handled on acceptance; an
// in-range coordinate runs one centroid memory read, one squaring and one accumulate
// per active cluster. A point end adds an argmin walk over the active clusters, the
// prior-assignment lookup and update, and a sum read and write per dimension of the
// sum update (active_dims, or MAX_DIMS on the first point a cluster receives in a
// pass), then loads the response. A readout reads the sum store, then loads the response.
// Reset: a sweep of all MAX_ROWS entries marks every prior assignment invalid; req_bus is
// held not ready during it. Sums, counts and the change counter clear at once.
// Stall: the response waits in an output register; the block keeps taking
// transactions and only holds in its response step until the slot frees.
module kmeans_assign_accumulate
   import kaa_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
   input  logic       clock,
   input  logic       reset,
   kaa_req_if.sink    req_bus,
   kaa_rsp_if.source  rsp_bus,
   kaa_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   kaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, arithmetic and response register
   kaa_datapath #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS),
      .MAX_ROWS     (MAX_ROWS),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .rsp    (rsp_bus),
      .csr    (csr_bus),
      .cmd    (cmd),
      .status (status)
   );

endmodule
